// ===== hw/rtl/cbez_pkg.sv =====
`timescale 1ns / 1ps

package cbez_pkg;

    localparam int COORD_W  = 10;
    localparam int NUM_REGS = 8;
    localparam int REG_IDX_W = 3;
    localparam int APB_ADDR_W = REG_IDX_W + 2;
    localparam int APB_DATA_W = 32;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [REG_IDX_W-1:0] reg_idx_t;

    localparam reg_idx_t REG_P0_X = 3'd0;
    localparam reg_idx_t REG_P0_Y = 3'd1;
    localparam reg_idx_t REG_P1_X = 3'd2;
    localparam reg_idx_t REG_P1_Y = 3'd3;
    localparam reg_idx_t REG_P2_X = 3'd4;
    localparam reg_idx_t REG_P2_Y = 3'd5;
    localparam reg_idx_t REG_P3_X = 3'd6;
    localparam reg_idx_t REG_P3_Y = 3'd7;

endpackage

// ===== hw/rtl/cbez_lerp_cell.sv =====
`timescale 1ns / 1ps

module cbez_lerp_cell #(
    parameter int IN_W   = 10,
    parameter int T_BITS = 10
) (
    input  logic                   aclk,
    input  logic                   load,
    input  logic [IN_W-1:0]        a,
    input  logic [IN_W-1:0]        b,
    input  logic [T_BITS:0]        t,
    output logic [IN_W+T_BITS-1:0] r
);

    localparam int PROD_W = IN_W + T_BITS + 1;
    localparam logic [T_BITS:0] SCALE = (T_BITS+1)'(1) << T_BITS;

    logic [T_BITS:0]        t_inv;
    logic [PROD_W-1:0]      sum;
    logic [IN_W+T_BITS-1:0] r_reg;
    logic [IN_W+T_BITS-1:0] r_next;

    assign t_inv = SCALE - t;

    // a*(S-t) + b*t never exceeds max(a,b)*S, so the top bit drops cleanly
    assign sum = PROD_W'(a) * PROD_W'(t_inv) + PROD_W'(b) * PROD_W'(t);
    assign r_next = sum[IN_W+T_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (load) begin
            r_reg <= r_next;
        end
    end

    assign r = r_reg;

endmodule

// ===== hw/rtl/cbez_level.sv =====
`timescale 1ns / 1ps

module cbez_level #(
    parameter int N      = 3,
    parameter int IN_W   = 10,
    parameter int T_BITS = 10
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [T_BITS:0]                 in_t,
    input  logic [N:0][IN_W-1:0]            in_x,
    input  logic [N:0][IN_W-1:0]            in_y,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [T_BITS:0]                 out_t,
    output logic [N-1:0][IN_W+T_BITS-1:0]   out_x,
    output logic [N-1:0][IN_W+T_BITS-1:0]   out_y
);

    logic            valid_reg;
    logic            valid_next;
    logic [T_BITS:0] t_reg;
    logic            load;

    // take a new beat when empty or when the downstream takes the held one
    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb begin
        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            t_reg <= in_t;
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_cell
        cbez_lerp_cell #(
            .IN_W   (IN_W),
            .T_BITS (T_BITS)
        ) u_cell_x (
            .aclk (aclk),
            .load (load),
            .a    (in_x[k]),
            .b    (in_x[k+1]),
            .t    (in_t),
            .r    (out_x[k])
        );

        cbez_lerp_cell #(
            .IN_W   (IN_W),
            .T_BITS (T_BITS)
        ) u_cell_y (
            .aclk (aclk),
            .load (load),
            .a    (in_y[k]),
            .b    (in_y[k+1]),
            .t    (in_t),
            .r    (out_y[k])
        );
    end

    assign out_valid = valid_reg;
    assign out_t     = t_reg;

endmodule

// ===== hw/rtl/cubic_bezier_point_eval_core.sv =====
`timescale 1ns / 1ps
// Each accepted input beat passes through the registered levels u_level1, u_level2 and
// u_level3 in turn to m_valid. Throughput: one point per cycle unless m_ready stalls;
// each level is a row of registered lerp cells that passes its results on unless stalled.
// Reset (aresetn low, synchronous) clears all pipeline valid bits and sets
// every control point register to 0.
module cubic_bezier_point_eval_core #(
    parameter int T_FRAC_BITS = 10
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [T_FRAC_BITS:0]           s_param_t,
    output logic                           m_valid,
    input  logic                           m_ready,
    output cbez_pkg::coord_t               m_x_pixel,
    output cbez_pkg::coord_t               m_y_pixel,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cbez_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [cbez_pkg::APB_DATA_W-1:0] pwdata,
    output logic [cbez_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    import cbez_pkg::*;

    localparam int TB = T_FRAC_BITS;
    localparam int W1 = COORD_W + TB;
    localparam int W2 = COORD_W + 2*TB;
    localparam int W3 = COORD_W + 3*TB;
    localparam logic [TB:0] SCALE = (TB+1)'(1) << TB;

    coord_t   ctrl_reg [NUM_REGS];
    reg_idx_t reg_idx;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                ctrl_reg[i] <= '0;
            end
        end else if (wr_en) begin
            ctrl_reg[reg_idx] <= pwdata[COORD_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        case (reg_idx)
            REG_P0_X: prdata[COORD_W-1:0] = ctrl_reg[REG_P0_X];
            REG_P0_Y: prdata[COORD_W-1:0] = ctrl_reg[REG_P0_Y];
            REG_P1_X: prdata[COORD_W-1:0] = ctrl_reg[REG_P1_X];
            REG_P1_Y: prdata[COORD_W-1:0] = ctrl_reg[REG_P1_Y];
            REG_P2_X: prdata[COORD_W-1:0] = ctrl_reg[REG_P2_X];
            REG_P2_Y: prdata[COORD_W-1:0] = ctrl_reg[REG_P2_Y];
            REG_P3_X: prdata[COORD_W-1:0] = ctrl_reg[REG_P3_X];
            REG_P3_Y: prdata[COORD_W-1:0] = ctrl_reg[REG_P3_Y];
            default:  prdata = '0;
        endcase
    end

    // clamp t above 1.0 to exactly 1.0
    logic [TB:0] t_sat;
    assign t_sat = (s_param_t > SCALE) ? SCALE : s_param_t;

    logic [3:0][COORD_W-1:0] pts_x;
    logic [3:0][COORD_W-1:0] pts_y;

    assign pts_x = {ctrl_reg[REG_P3_X], ctrl_reg[REG_P2_X],
                    ctrl_reg[REG_P1_X], ctrl_reg[REG_P0_X]};
    assign pts_y = {ctrl_reg[REG_P3_Y], ctrl_reg[REG_P2_Y],
                    ctrl_reg[REG_P1_Y], ctrl_reg[REG_P0_Y]};

    logic               l1_valid, l1_ready;
    logic [TB:0]        l1_t;
    logic [2:0][W1-1:0] l1_x, l1_y;

    logic               l2_valid, l2_ready;
    logic [TB:0]        l2_t;
    logic [1:0][W2-1:0] l2_x, l2_y;

    logic [TB:0]        l3_t;
    logic [0:0][W3-1:0] l3_x, l3_y;

    cbez_level #(.N(3), .IN_W(COORD_W), .T_BITS(TB)) u_level1 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_t      (t_sat),
        .in_x      (pts_x),
        .in_y      (pts_y),
        .out_valid (l1_valid),
        .out_ready (l1_ready),
        .out_t     (l1_t),
        .out_x     (l1_x),
        .out_y     (l1_y)
    );

    cbez_level #(.N(2), .IN_W(W1), .T_BITS(TB)) u_level2 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (l1_valid),
        .in_ready  (l1_ready),
        .in_t      (l1_t),
        .in_x      (l1_x),
        .in_y      (l1_y),
        .out_valid (l2_valid),
        .out_ready (l2_ready),
        .out_t     (l2_t),
        .out_x     (l2_x),
        .out_y     (l2_y)
    );

    cbez_level #(.N(1), .IN_W(W2), .T_BITS(TB)) u_level3 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (l2_valid),
        .in_ready  (l2_ready),
        .in_t      (l2_t),
        .in_x      (l2_x),
        .in_y      (l2_y),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_t     (l3_t),
        .out_x     (l3_x),
        .out_y     (l3_y)
    );

    // drop the S^3 scale: truncate to whole pixels
    assign m_x_pixel = l3_x[0][3*TB +: COORD_W];
    assign m_y_pixel = l3_y[0][3*TB +: COORD_W];

    // t is not needed past the last level
    logic unused_t;
    assign unused_t = ^l3_t;

endmodule

// ===== tb/cubic_bezier_point_eval_core_tb.sv =====
`timescale 1ns / 1ps

module cubic_bezier_point_eval_core_tb;
    import cbez_pkg::*;

    localparam int  T_BITS = 10;
    localparam int  RANDOM_PHASES = 5;
    localparam int  ITEMS_PER_PHASE = 198;
    localparam int  HOLD_OFF_CYCLES = 80;

    typedef logic [T_BITS:0] param_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } point_t;

    class point_scoreboard;
        coord_t ctrl [NUM_REGS];
        point_t pending_q [$];
        int     accepted;
        int     mismatches;

        function new();
            foreach (ctrl[i]) ctrl[i] = '0;
            accepted   = 0;
            mismatches = 0;
        endfunction

        function void set_ctrl(reg_idx_t idx, logic [APB_DATA_W-1:0] value);
            ctrl[idx] = value[COORD_W-1:0];
        endfunction

        function int pending();
            return pending_q.size();
        endfunction

        // One interpolation step, kept exact: a*(S-t) + b*t.
        function logic [63:0] blend(logic [63:0] a, logic [63:0] b, logic [63:0] t);
            return a * ((64'd1 << T_BITS) - t) + b * t;
        endfunction

        function coord_t curve_axis(coord_t c0, coord_t c1, coord_t c2, coord_t c3,
                                    logic [63:0] t);
            logic [63:0] a0, a1, a2, b0, b1, r;
            a0 = blend(64'(c0), 64'(c1), t);
            a1 = blend(64'(c1), 64'(c2), t);
            a2 = blend(64'(c2), 64'(c3), t);
            b0 = blend(a0, a1, t);
            b1 = blend(a1, a2, t);
            r  = blend(b0, b1, t);
            return coord_t'(r >> (3 * T_BITS));
        endfunction

        function void note_param(param_t raw);
            logic [63:0] t;
            point_t      p;
            t = 64'(raw);
            // clamp anything past 1.0 to the last control point
            if (t > (64'd1 << T_BITS)) t = 64'd1 << T_BITS;
            p.x = curve_axis(ctrl[REG_P0_X], ctrl[REG_P1_X], ctrl[REG_P2_X], ctrl[REG_P3_X], t);
            p.y = curve_axis(ctrl[REG_P0_Y], ctrl[REG_P1_Y], ctrl[REG_P2_Y], ctrl[REG_P3_Y], t);
            pending_q = {pending_q, p};
            accepted++;
        endfunction

        function void check_point(coord_t x, coord_t y);
            point_t exp_p;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected point x=%0d y=%0d", $realtime, x, y);
                return;
            end
            exp_p = pending_q.pop_front();
            if (exp_p.x !== x || exp_p.y !== y) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: point mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
                             $realtime, exp_p.x, exp_p.y, x, y);
            end
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    param_t                s_param_t = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    coord_t                m_x_pixel;
    coord_t                m_y_pixel;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    point_scoreboard sb = new();
    bit              steady = 1'b0;
    bit              held_off = 1'b0;

    cubic_bezier_point_eval_core #(.T_FRAC_BITS(T_BITS)) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_param_t (s_param_t),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_x_pixel (m_x_pixel),
        .m_y_pixel (m_y_pixel),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #4 aclk = ~aclk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 2);
        if (r < 97) return $urandom_range(3, 6);
        return $urandom_range(10, 30);
    endfunction

    function automatic param_t pick_param();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return param_t'($urandom_range(0, 1 << T_BITS));
        if (r < 88) return (r < 84) ? param_t'(0) : param_t'(1 << T_BITS);
        return param_t'($urandom_range((1 << T_BITS) + 1, (2 << T_BITS) - 1));
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat.
    task automatic drive_param(param_t t);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   = 1'b1;
        s_param_t = t;
        do @(posedge aclk); while (!s_ready);
        sb.note_param(t);
        @(negedge aclk);
    endtask

    task automatic write_ctrl(reg_idx_t idx, logic [APB_DATA_W-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        sb.set_ctrl(idx, value);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic drain();
        s_valid = 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (6) @(negedge aclk);
    endtask

    task automatic load_curve(logic [APB_DATA_W-1:0] vals [NUM_REGS]);
        drain();
        for (int i = 0; i < NUM_REGS; i++) write_ctrl(reg_idx_t'(i), vals[i]);
    endtask

    task automatic run_corners();
        param_t corner_ts [14] = '{11'd0, 11'd1, 11'd255, 11'd511, 11'd512, 11'd513,
                                   11'd1023, 11'd1024, 11'd1025, 11'd1536, 11'd2046,
                                   11'd2047, 11'h555, 11'h2AA};
        foreach (corner_ts[i]) drive_param(corner_ts[i]);
    endtask

    task automatic run_random(int count);
        for (int i = 0; i < count; i++) begin
            if (i % 50 == 0) steady = ($urandom_range(0, 3) == 0);
            drive_param(pick_param());
        end
        steady = 1'b0;
    endtask

    // Receiver side: random stalls, one long hold-off once 500 points have been accepted.
    initial begin
        int r;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!held_off && sb.accepted >= 500) begin
                m_ready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
                held_off = 1'b1;
            end else if (steady) begin
                m_ready = 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    m_ready = 1'b1;
                end else if (r < 96) begin
                    m_ready = 1'b0;
                end else begin
                    m_ready = 1'b0;
                    repeat ($urandom_range(5, 25)) @(negedge aclk);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_point(m_x_pixel, m_y_pixel);
    end

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        logic [APB_DATA_W-1:0] vals [NUM_REGS];
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // reset state: every control point at the origin
        run_corners();

        // all control points at the far corner; upper data bits must be dropped
        foreach (vals[i]) vals[i] = 32'hFFFF_FFFF;
        load_curve(vals);
        run_corners();
        run_random(60);

        // zig-zag between the extremes
        vals = '{32'd0, 32'd1023, 32'd1023, 32'd0, 32'd0, 32'd1023, 32'd1023, 32'd0};
        load_curve(vals);
        run_corners();
        run_random(60);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            foreach (vals[i])
                vals[i] = ($urandom_range(0, 3) == 0) ? $urandom()
                                                       : $urandom_range(0, 1023);
            load_curve(vals);
            run_random(ITEMS_PER_PHASE);
        end

        drain();
        repeat (4) @(negedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
